// ----- hw/rtl/sads_pkg.sv -----
// shared types and codes for the shared array double stack
package sads_pkg;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 6;

   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;    // request beat taken this cycle
      logic load;      // write the response register
      logic from_ram;  // response carries the byte read from memory
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_read;  // offered request is a pop or peek on a nonempty side
   } dp_status_type;

endpackage

// ----- hw/rtl/sads_if.sv -----
// request and response channel interfaces
interface sads_req_if;
   logic                          valid;
   logic                          ready;
   logic [sads_pkg::CMD_W-1:0]    cmd;
   logic                          side;
   logic [sads_pkg::BYTE_W-1:0]   push_value;

   modport source (output valid, output cmd, output side, output push_value, input ready);
   modport sink   (input valid, input cmd, input side, input push_value, output ready);
endinterface

interface sads_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sads_pkg::STATUS_W-1:0] status;
   logic [sads_pkg::BYTE_W-1:0]   read_value;
   logic [sads_pkg::COUNT_W-1:0]  low_count;
   logic [sads_pkg::COUNT_W-1:0]  high_count;
   logic                          low_empty;
   logic                          high_empty;

   modport source (output valid, output status, output read_value, output low_count,
                   output high_count, output low_empty, output high_empty, input ready);
   modport sink   (input valid, input status, input read_value, input low_count,
                   input high_count, input low_empty, input high_empty, output ready);
endinterface

// ----- hw/rtl/sads_ram.sv -----
// generic single write port ram with registered read
module sads_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sads_ctrl.sv -----
// handshake controller for the double stack
module sads_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sads_pkg::dp_status_type dp_status,
   output sads_pkg::ctl_cmd_type   ctl_cmd
);

   sads_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                accept;

   // response register can take a new beat this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sads_pkg::ST_IDLE: begin
            if (accept && dp_status.needs_read) begin
               state_in = sads_pkg::ST_READ;
            end
         end
         sads_pkg::ST_READ: begin
            if (out_free) begin
               state_in = sads_pkg::ST_IDLE;
            end
         end
         default: state_in = sads_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready        = 1'b0;
      ctl_cmd.accept   = 1'b0;
      ctl_cmd.load     = 1'b0;
      ctl_cmd.from_ram = 1'b0;
      unique case (state_ff)
         sads_pkg::ST_IDLE: begin
            req_ready      = out_free;
            ctl_cmd.accept = accept;
            ctl_cmd.load   = accept && !dp_status.needs_read;
         end
         sads_pkg::ST_READ: begin
            ctl_cmd.load     = out_free;
            ctl_cmd.from_ram = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (ctl_cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sads_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/sads_dpath.sv -----
// fill counters, shared byte memory and response register
module sads_dpath #(
   parameter int DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sads_pkg::ctl_cmd_type           ctl_cmd,
   output sads_pkg::dp_status_type         dp_status,
   input  logic [sads_pkg::CMD_W-1:0]      req_cmd,
   input  logic                            req_side,
   input  logic [sads_pkg::BYTE_W-1:0]     req_push_value,
   output logic [sads_pkg::STATUS_W-1:0]   rsp_status,
   output logic [sads_pkg::BYTE_W-1:0]     rsp_read_value,
   output logic [sads_pkg::COUNT_W-1:0]    rsp_low_count,
   output logic [sads_pkg::COUNT_W-1:0]    rsp_high_count,
   output logic                            rsp_low_empty,
   output logic                            rsp_high_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic [CW-1:0] low_fill_ff, low_fill_in;
   logic [CW-1:0] high_fill_ff, high_fill_in;

   logic [sads_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [sads_pkg::BYTE_W-1:0]   read_ff, read_in;
   logic [sads_pkg::COUNT_W-1:0]  low_cnt_ff, high_cnt_ff;
   logic                          low_empty_ff, high_empty_ff;

   logic [SW-1:0] fill_sum;
   logic          full;
   logic          side_empty;
   logic          is_push, is_pop, is_peek;
   logic          push_ok, pop_ok;
   logic [sads_pkg::STATUS_W-1:0] op_status;

   logic [CW-1:0] wr_index, rd_index;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_en, rd_en;
   logic [sads_pkg::BYTE_W-1:0] ram_rd_data;

   logic [CW+sads_pkg::COUNT_W-1:0] low_ext, high_ext;

   assign is_push = (req_cmd == sads_pkg::CMD_PUSH);
   assign is_pop  = (req_cmd == sads_pkg::CMD_POP);
   assign is_peek = (req_cmd == sads_pkg::CMD_PEEK);

   assign fill_sum   = {1'b0, low_fill_ff} + {1'b0, high_fill_ff};
   assign full       = (fill_sum >= DEPTH_S);
   assign side_empty = req_side ? (high_fill_ff == '0) : (low_fill_ff == '0);

   assign push_ok = is_push && !full;
   assign pop_ok  = is_pop && !side_empty;

   assign dp_status.needs_read = (is_pop || is_peek) && !side_empty;

   always_comb begin
      if (is_push && full) begin
         op_status = sads_pkg::STATUS_FULL;
      end else if ((is_pop || is_peek) && side_empty) begin
         op_status = sads_pkg::STATUS_EMPTY;
      end else begin
         op_status = sads_pkg::STATUS_DONE;
      end
   end

   always_comb begin
      low_fill_in  = low_fill_ff;
      high_fill_in = high_fill_ff;
      if (ctl_cmd.accept) begin
         if (push_ok && !req_side) begin
            low_fill_in = low_fill_ff + ONE_C;
         end
         if (push_ok && req_side) begin
            high_fill_in = high_fill_ff + ONE_C;
         end
         if (pop_ok && !req_side) begin
            low_fill_in = low_fill_ff - ONE_C;
         end
         if (pop_ok && req_side) begin
            high_fill_in = high_fill_ff - ONE_C;
         end
      end
   end

   // low stack grows up from entry zero, high stack down from the last entry
   assign wr_index = req_side ? (DEPTH_C - ONE_C - high_fill_ff) : low_fill_ff;
   assign rd_index = req_side ? (DEPTH_C - high_fill_ff) : (low_fill_ff - ONE_C);
   assign wr_addr  = wr_index[AW-1:0];
   assign rd_addr  = rd_index[AW-1:0];
   assign wr_en    = ctl_cmd.accept && push_ok;
   assign rd_en    = ctl_cmd.accept && dp_status.needs_read;

   sads_ram #(
      .WIDTH (sads_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign status_in = ctl_cmd.from_ram ? sads_pkg::STATUS_DONE : op_status;
   assign read_in   = ctl_cmd.from_ram ? ram_rd_data : '0;

   // count fields show the low bits of the fill
   assign low_ext  = {{sads_pkg::COUNT_W{1'b0}}, low_fill_in};
   assign high_ext = {{sads_pkg::COUNT_W{1'b0}}, high_fill_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         low_fill_ff  <= '0;
         high_fill_ff <= '0;
      end else begin
         low_fill_ff  <= low_fill_in;
         high_fill_ff <= high_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         status_ff     <= status_in;
         read_ff       <= read_in;
         low_cnt_ff    <= low_ext[sads_pkg::COUNT_W-1:0];
         high_cnt_ff   <= high_ext[sads_pkg::COUNT_W-1:0];
         low_empty_ff  <= (low_fill_in == '0);
         high_empty_ff <= (high_fill_in == '0);
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = read_ff;
   assign rsp_low_count  = low_cnt_ff;
   assign rsp_high_count = high_cnt_ff;
   assign rsp_low_empty  = low_empty_ff;
   assign rsp_high_empty = high_empty_ff;

endmodule

// ----- hw/rtl/shared_array_double_stack_core.sv -----
// top level of the shared array double stack
//
//  channel    dir   handshake              beat contents
//  req_chan   in    valid / ready          cmd, side, push_value
//  rsp_chan   out   valid / ready          status, read_value, low_count,
//                                          high_count, low_empty, high_empty
//
// push, refused ops and unused commands: one beat per cycle while the response drains
// pop or peek that hits a stack: no request is taken in the read state, which waits for the registered memory read
// reset clears both fill counts; memory contents stay undefined until pushed
// a response waits in the output register, and the next request is taken
// in the same cycle that register is freed or drained
module shared_array_double_stack_core #(
   parameter int DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   sads_req_if.sink   req_chan,
   sads_rsp_if.source rsp_chan
);

   sads_pkg::ctl_cmd_type   ctl_cmd;
   sads_pkg::dp_status_type dp_status;

   sads_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   sads_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctl_cmd        (ctl_cmd),
      .dp_status      (dp_status),
      .req_cmd        (req_chan.cmd),
      .req_side       (req_chan.side),
      .req_push_value (req_chan.push_value),
      .rsp_status     (rsp_chan.status),
      .rsp_read_value (rsp_chan.read_value),
      .rsp_low_count  (rsp_chan.low_count),
      .rsp_high_count (rsp_chan.high_count),
      .rsp_low_empty  (rsp_chan.low_empty),
      .rsp_high_empty (rsp_chan.high_empty)
   );

endmodule

// ----- sim/sads_reply_checker.sv -----
// checker that mirrors the double stack and compares every response beat
`timescale 1ns / 1ps
module sads_reply_checker #(
   parameter int DEPTH = 32
) (
   input  logic clock,
   input  logic reset,
   sads_req_if  req_mon,
   sads_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count,
   output int   full_count,
   output int   empty_count
);

   typedef struct packed {
      logic [sads_pkg::STATUS_W-1:0] status;
      logic [sads_pkg::BYTE_W-1:0]   read_value;
      logic [sads_pkg::COUNT_W-1:0]  low_count;
      logic [sads_pkg::COUNT_W-1:0]  high_count;
      logic                          low_empty;
      logic                          high_empty;
   } stack_reply_type;

   logic [sads_pkg::BYTE_W-1:0] mirror_mem [DEPTH];
   int                          low_depth = 0;
   int                          high_depth = 0;
   stack_reply_type             reply_due [$];

   int n_mismatch = 0;
   int n_checked = 0;
   int n_full = 0;
   int n_empty = 0;

   // applies one operation to the mirrored stacks and returns the reply it must produce
   function automatic stack_reply_type apply_stack_op(
      input logic [sads_pkg::CMD_W-1:0]  op,
      input logic                        side,
      input logic [sads_pkg::BYTE_W-1:0] value);
      stack_reply_type r;
      int              top;
      r = '0;
      r.status = sads_pkg::STATUS_DONE;
      if (op == sads_pkg::CMD_PUSH) begin
         if (low_depth + high_depth >= DEPTH) begin
            r.status = sads_pkg::STATUS_FULL;
         end else if (!side) begin
            mirror_mem[low_depth] = value;
            low_depth++;
         end else begin
            high_depth++;
            mirror_mem[DEPTH - high_depth] = value;
         end
      end else if (op == sads_pkg::CMD_POP || op == sads_pkg::CMD_PEEK) begin
         if ((side ? high_depth : low_depth) == 0) begin
            r.status = sads_pkg::STATUS_EMPTY;
         end else begin
            top = side ? DEPTH - high_depth : low_depth - 1;
            r.read_value = mirror_mem[top];
            if (op == sads_pkg::CMD_POP) begin
               if (side) high_depth--;
               else low_depth--;
            end
         end
      end
      r.low_count  = low_depth[sads_pkg::COUNT_W-1:0];
      r.high_count = high_depth[sads_pkg::COUNT_W-1:0];
      r.low_empty  = (low_depth == 0);
      r.high_empty = (high_depth == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns, response %0d: %s", $time, n_checked, msg);
      n_mismatch++;
   endtask

   task automatic check_field(input string name, input logic [sads_pkg::BYTE_W-1:0] got,
                              input logic [sads_pkg::BYTE_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : watch
      stack_reply_type want;
      if (reset) begin
         low_depth  = 0;
         high_depth = 0;
         reply_due.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (reply_due.size() == 0) begin
               report_mismatch("response beat with nothing outstanding");
            end else begin
               want = reply_due.pop_front();
               check_field("status", rsp_mon.status, want.status);
               check_field("read_value", rsp_mon.read_value, want.read_value);
               check_field("low_count", rsp_mon.low_count, want.low_count);
               check_field("high_count", rsp_mon.high_count, want.high_count);
               check_field("low_empty", rsp_mon.low_empty, want.low_empty);
               check_field("high_empty", rsp_mon.high_empty, want.high_empty);
            end
            n_checked++;
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            want = apply_stack_op(req_mon.cmd, req_mon.side, req_mon.push_value);
            if (want.status == sads_pkg::STATUS_FULL) n_full++;
            if (want.status == sads_pkg::STATUS_EMPTY) n_empty++;
            reply_due.push_back(want);
         end
      end
      // counters leave through nonblocking updates so the top never races them
      fail_count    <= n_mismatch;
      pending_count <= reply_due.size();
      checked_count <= n_checked;
      full_count    <= n_full;
      empty_count   <= n_empty;
   end

endmodule

// ----- sim/tb_shared_array_double_stack_core.sv -----
// testbench top: clock, reset, stimulus and verdict for the double stack core
`timescale 1ns / 1ps
module tb_shared_array_double_stack_core;

   localparam int DEPTH        = 32;
   localparam int RANDOM_ITEMS = 850;
   localparam int HOLD_CYCLES  = 160;

   // the unused command code, which the block ignores
   localparam logic [sads_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int fail_count;
   int pending_count;
   int checked_count;
   int full_count;
   int empty_count;

   int send_idle_pct = 32;
   int recv_idle_pct = 58;
   bit hold_rsp = 1'b0;
   int beats_sent = 0;

   sads_req_if req_bus ();
   sads_rsp_if rsp_bus ();

   shared_array_double_stack_core #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   sads_reply_checker #(
      .DEPTH(DEPTH)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .checked_count(checked_count),
      .full_count   (full_count),
      .empty_count  (empty_count)
   );

   always #6 clock = ~clock;

   initial begin
      #2_000_000;
      $display("timeout with %0d responses still outstanding", pending_count);
      $display("RESULT: ERROR");
      $finish;
   end

   // offers one beat after an optional idle gap and returns at the edge that takes it
   task automatic send_beat(input logic [sads_pkg::CMD_W-1:0] op, input logic side,
                            input logic [sads_pkg::BYTE_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= op;
      req_bus.side       <= side;
      req_bus.push_value <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      beats_sent++;
   endtask

   // response side: random back-pressure plus one long hold-off on request
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            @(posedge clock);
         end
      end
   end

   initial begin
      int                          seg_left;
      int                          mode;
      int                          side_bias;
      int                          roll;
      logic [sads_pkg::CMD_W-1:0]  op;
      logic                        side;
      logic [sads_pkg::BYTE_W-1:0] value;

      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= sads_pkg::CMD_PUSH;
      req_bus.side       <= 1'b0;
      req_bus.push_value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty sides, ignored command, byte extremes on both stacks
      send_beat(sads_pkg::CMD_POP,  1'b0, 8'h00);
      send_beat(sads_pkg::CMD_PEEK, 1'b0, 8'hFF);
      send_beat(sads_pkg::CMD_POP,  1'b1, 8'h00);
      send_beat(sads_pkg::CMD_PEEK, 1'b1, 8'hFF);
      send_beat(CMD_NONE, 1'b0, 8'hAA);
      send_beat(CMD_NONE, 1'b1, 8'h55);
      send_beat(sads_pkg::CMD_PUSH, 1'b0, 8'h00);
      send_beat(sads_pkg::CMD_PUSH, 1'b0, 8'hFF);
      send_beat(sads_pkg::CMD_PUSH, 1'b1, 8'hFF);
      send_beat(sads_pkg::CMD_PUSH, 1'b1, 8'h00);
      send_beat(sads_pkg::CMD_PEEK, 1'b0, 8'h00);
      send_beat(sads_pkg::CMD_PEEK, 1'b1, 8'h00);
      send_beat(sads_pkg::CMD_POP,  1'b0, 8'h00);
      send_beat(sads_pkg::CMD_POP,  1'b0, 8'h00);
      send_beat(sads_pkg::CMD_POP,  1'b0, 8'h00);
      send_beat(sads_pkg::CMD_PEEK, 1'b1, 8'h00);
      send_beat(sads_pkg::CMD_POP,  1'b1, 8'h00);
      send_beat(sads_pkg::CMD_POP,  1'b1, 8'h00);
      send_beat(sads_pkg::CMD_POP,  1'b1, 8'h00);
      send_beat(sads_pkg::CMD_PUSH, 1'b0, 8'hA5);
      send_beat(sads_pkg::CMD_PUSH, 1'b1, 8'h5A);
      send_beat(sads_pkg::CMD_PEEK, 1'b0, 8'h00);
      send_beat(sads_pkg::CMD_PEEK, 1'b1, 8'h00);

      // segments rotate fill-heavy, drain-heavy and mixed so both full and empty recur
      seg_left  = 0;
      mode      = 2;
      side_bias = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 58;
            recv_idle_pct = 32;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n == 2 * RANDOM_ITEMS / 3 + 40) hold_rsp = 1'b1;
         if (seg_left == 0) begin
            seg_left  = $urandom_range(30, 70);
            mode      = (mode + 1) % 3;
            side_bias = $urandom_range(0, 2);
         end
         seg_left--;

         roll = $urandom_range(0, 99);
         case (mode)
            0: begin
               op = (roll < 90) ? sads_pkg::CMD_PUSH : (roll < 94) ? sads_pkg::CMD_POP :
                    (roll < 98) ? sads_pkg::CMD_PEEK : CMD_NONE;
            end
            1: begin
               op = (roll < 13) ? sads_pkg::CMD_PUSH : (roll < 83) ? sads_pkg::CMD_POP :
                    (roll < 98) ? sads_pkg::CMD_PEEK : CMD_NONE;
            end
            default: begin
               op = (roll < 45) ? sads_pkg::CMD_PUSH : (roll < 75) ? sads_pkg::CMD_POP :
                    (roll < 97) ? sads_pkg::CMD_PEEK : CMD_NONE;
            end
         endcase

         roll = $urandom_range(0, 99);
         case (side_bias)
            1:       side = (roll < 20);
            2:       side = (roll < 80);
            default: side = (roll < 50);
         endcase

         roll = $urandom_range(0, 9);
         value = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom_range(0, 255));

         send_beat(op, side, value);
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);

      $display("covered %0d request beats, %0d responses checked", beats_sent, checked_count);
      $display("%0d pushes refused full, %0d reads refused empty, idle mix 32/58, 58/32 and none, one %0d-cycle hold-off",
               full_count, empty_count, HOLD_CYCLES);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- shared_array_double_stack_core.f -----
hw/rtl/sads_pkg.sv
hw/rtl/sads_if.sv
hw/rtl/sads_ram.sv
hw/rtl/sads_ctrl.sv
hw/rtl/sads_dpath.sv
hw/rtl/shared_array_double_stack_core.sv
sim/sads_reply_checker.sv
sim/tb_shared_array_double_stack_core.sv
